/* rtl/radix_integer_to_ascii_macros.svh */
// Assertion macros for the radix integer to ASCII converter.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef RADIX_INTEGER_TO_ASCII_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define RIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ria: same-cycle check failed");
// Next-cycle implication
`define RIA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ria: next-cycle check failed");
`else
`define RIA_ASSERT_IMP(lbl, ante, cons)
`define RIA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/ria_pkg.sv */
`timescale 1ns / 1ps

package ria_pkg;

  // Default word width and register map
  localparam int VALUE_BITS_DEF = 32;
  localparam int CFG_DATA_W     = 5;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGNED = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [CFG_DATA_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [CFG_DATA_W-1:0] RADIX_MAX   = 5'd16;

  // Characters
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_UPPERA = 8'h41;

  // Bits of the working word consumed per divide step
  localparam int CHUNK_BITS = 8;

  // Microcode
  typedef logic [2:0] step_t;

  localparam step_t ST_WAIT = 3'd0;
  localparam step_t ST_DIV  = 3'd1;
  localparam step_t ST_PUSH = 3'd2;
  localparam step_t ST_SIGN = 3'd3;
  localparam step_t ST_EMIT = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_PUSH,
    OP_SIGN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_ACCEPT,
    C_CHUNK_MORE,
    C_QUOT_NZ,
    C_SIGN_BUSY,
    C_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;   // taken when the condition holds
    step_t next;   // taken otherwise
  } ctrl_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    case (pc)
      ST_WAIT: w = '{op: OP_LOAD, cond: C_NO_ACCEPT,  jump: ST_WAIT, next: ST_DIV};
      ST_DIV:  w = '{op: OP_DIV,  cond: C_CHUNK_MORE, jump: ST_DIV,  next: ST_PUSH};
      ST_PUSH: w = '{op: OP_PUSH, cond: C_QUOT_NZ,    jump: ST_DIV,  next: ST_SIGN};
      ST_SIGN: w = '{op: OP_SIGN, cond: C_SIGN_BUSY,  jump: ST_SIGN, next: ST_EMIT};
      ST_EMIT: w = '{op: OP_EMIT, cond: C_EMIT_MORE,  jump: ST_EMIT, next: ST_WAIT};
      default: w = '{op: OP_NONE, cond: C_NEVER,      jump: ST_WAIT, next: ST_WAIT};
    endcase
    return w;
  endfunction

  // Digit value to upper-case ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_UPPERA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* rtl/radix_integer_to_ascii.sv */
// Channel | Direction | Ports                                                | Moves
// in      | in        | in_valid, in_stall, in_value                         | one word per item
// out     | out       | out_valid, out_stall, out_character, out_last_char   | one char per item
// cfg     | in        | cfg_we, cfg_index, cfg_data                          | register writes
//
// One word at a time: for each digit the divide unit runs its divide steps
// (8 quotient bits per cycle, then a push to the digit stack), then a sign step
// (sends any '-'), then the digits go out from the stack, most significant first;
// a new word is accepted only after the last character has been loaded.
// Reset (rst_n low, synchronous): radix 10, signed mode, sequencer waiting. in_stall
// is high from acceptance to the last character's load; out_stall holds sign and emit.
`timescale 1ns / 1ps
`include "radix_integer_to_ascii_macros.svh"

module radix_integer_to_ascii #(
  parameter int VALUE_BITS = ria_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [VALUE_BITS-1:0]          in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_character,
  output logic                           out_last_char,
  input  logic                           cfg_we,
  input  logic [ria_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ria_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ria_pkg::*;

  localparam int NCH   = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int DW    = NCH * CHUNK_BITS;
  localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int DEPTH = VALUE_BITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  // Registers
  step_t                 pc_r, pc_nxt;
  logic [CFG_DATA_W-1:0] radix_r;
  logic                  signed_r;
  logic [DW-1:0]         div_r, div_nxt;
  logic [3:0]            rem_r, rem_nxt;
  logic [CHW-1:0]        chunk_r, chunk_nxt;
  logic [NW-1:0]         ndig_r, ndig_nxt;
  logic                  neg_r, neg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  // Digit stack
  logic [3:0]            stack_mem [DEPTH];
  logic [3:0]            rd_data_r;
  logic [NW-1:0]         rd_cnt;
  logic [AW-1:0]         rd_addr;
  logic                  push_en;

  // Control and datapath helpers
  ctrl_t                 ctrl;
  logic                  in_acc;
  logic                  out_free;
  logic                  chunk_last;
  logic                  jump_hit;
  logic [CFG_DATA_W-1:0] base;
  logic [VALUE_BITS-1:0] mag;
  logic [CHUNK_BITS-1:0] top_bits;
  logic [CHUNK_BITS-1:0] qbits;
  logic [4:0]            trial;
  logic [3:0]            rem_step;

  assign in_stall      = (pc_r != ST_WAIT);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

  // Out-of-range radix values clamp to the nearest legal base
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  // Divide step: eight restoring subtractions on a 4-bit remainder
  always_comb begin
    top_bits = div_r[DW-1 -: CHUNK_BITS];
    rem_step = rem_r;
    qbits    = '0;
    trial    = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      trial = {rem_step, top_bits[i]};
      if (trial >= base) begin
        qbits[i] = 1'b1;
        trial    = trial - base;
      end
      rem_step = trial[3:0];
    end
  end

  assign chunk_last = (chunk_r == CHW'(NCH - 1));

  // Sequencer: decode the control word and form next values
  always_comb begin
    ctrl          = ucode(pc_r);
    in_acc        = in_valid && (pc_r == ST_WAIT);
    out_free      = !out_valid_r || !out_stall;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    ndig_nxt      = ndig_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    push_en       = 1'b0;
    mag           = in_value;

    case (ctrl.op)
      OP_LOAD: begin
        if (in_acc) begin
          neg_nxt = signed_r && in_value[VALUE_BITS-1];
          if (signed_r && in_value[VALUE_BITS-1]) begin
            mag = VALUE_BITS'(0) - in_value;
          end
          div_nxt   = DW'(mag);
          rem_nxt   = '0;
          chunk_nxt = '0;
          ndig_nxt  = '0;
        end
      end
      OP_DIV: begin
        div_nxt   = (div_r << CHUNK_BITS) | DW'(qbits);
        rem_nxt   = rem_step;
        chunk_nxt = chunk_last ? '0 : chunk_r + 1'b1;
      end
      OP_PUSH: begin
        push_en  = 1'b1;
        ndig_nxt = ndig_r + 1'b1;
        rem_nxt  = '0;
      end
      OP_SIGN: begin
        if (neg_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_data_r);
          out_last_nxt  = (ndig_r == NW'(1));
          ndig_nxt      = ndig_r - 1'b1;
        end
      end
      default: begin
      end
    endcase

    case (ctrl.cond)
      C_NO_ACCEPT:  jump_hit = !in_acc;
      C_CHUNK_MORE: jump_hit = !chunk_last;
      C_QUOT_NZ:    jump_hit = (div_r != '0);
      C_SIGN_BUSY:  jump_hit = neg_r && !out_free;
      C_EMIT_MORE:  jump_hit = !out_free || (ndig_r != NW'(1));
      default:      jump_hit = 1'b0;
    endcase

    pc_nxt = jump_hit ? ctrl.jump : ctrl.next;
  end

  // Read the top of stack for the coming cycle
  assign rd_cnt  = ndig_nxt - 1'b1;
  assign rd_addr = rd_cnt[AW-1:0];

  // Digit stack memory
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[ndig_r[AW-1:0]] <= rem_r;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_WAIT;
      chunk_r     <= '0;
      ndig_r      <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      radix_r     <= RADIX_RESET;
      signed_r    <= 1'b1;
    end else begin
      pc_r        <= pc_nxt;
      chunk_r     <= chunk_nxt;
      ndig_r      <= ndig_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_RADIX:  radix_r  <= cfg_data;
          CFG_IDX_SIGNED: signed_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Checks
  `RIA_ASSERT_IMP(a_stack_bound, 1'b1, ndig_r <= NW'(DEPTH))
  `RIA_ASSERT_IMP(a_last_is_digit, out_valid_r && out_last_r, out_char_r != CHAR_MINUS)
  `RIA_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, (pc_r == ST_DIV) && (chunk_r == '0) && (rem_r == 4'd0))
  `RIA_ASSERT_NXT(a_last_to_wait, (ctrl.op == OP_EMIT) && out_free && (ndig_r == NW'(1)), (pc_r == ST_WAIT) && out_last_r)

endmodule
